// ----- src/dht_pkg.sv -----
// shared types and constants for the double hash table unit
// no dependencies

package dht_pkg;

  localparam int TABLE_SIZE = 64;
  localparam int SLOT_W     = 6;
  localparam int KEY_W      = 31;
  localparam int SIZE_W     = 7;
  localparam int Q_W        = 6;
  localparam int CNT_W      = 7;
  localparam int STATUS_W   = 3;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int BIT_CNT_W  = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(13);
  localparam logic [Q_W-1:0]    Q_RESET    = Q_W'(11);
  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(TABLE_SIZE);

  localparam logic [CMD_W-1:0] CMD_INSERT = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_SEARCH = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_READ   = CMD_W'(2);

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MODULUS = CFG_IDX_W'(1);

  localparam logic [STATUS_W-1:0] ST_INSERTED  = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_FULL      = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_FOUND     = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = STATUS_W'(3);
  localparam logic [STATUS_W-1:0] ST_READ      = STATUS_W'(4);
  localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = STATUS_W'(5);

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot_index;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    stored_key;
    logic [CNT_W-1:0]    collisions;
  } out_beat_t;

  typedef struct packed {
    logic [SLOT_W-1:0] base;
    logic [SLOT_W-1:0] stepm;
  } hash_t;

endpackage

// ----- src/dht_hash.sv -----
// bit-serial remainder unit: key mod m, key mod q, then (q - key mod q) mod m
// depends on dht_pkg

module dht_hash (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dht_pkg::KEY_W-1:0]  key,
  input  logic [dht_pkg::SIZE_W-1:0] m,
  input  logic [dht_pkg::Q_W-1:0]    q,
  output logic                       done,
  output dht_pkg::hash_t             hash
);

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_KEY  = 4'b0010,
    H_STEP = 4'b0100,
    H_DONE = 4'b1000
  } hstate_t;

  hstate_t                        state_r, state_nxt;
  logic [dht_pkg::BIT_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [dht_pkg::KEY_W-1:0]      key_r, key_nxt;
  logic [dht_pkg::Q_W-1:0]        step_r, step_nxt;
  logic [dht_pkg::SIZE_W-1:0]     rem_m_r, rem_m_nxt;
  logic [dht_pkg::Q_W-1:0]        rem_q_r, rem_q_nxt;
  logic [dht_pkg::SIZE_W:0]       tm;
  logic [dht_pkg::Q_W:0]          tq;
  logic                           in_bit;

  always_comb begin
    in_bit = (state_r == H_STEP) ? step_r[dht_pkg::Q_W-1] : key_r[dht_pkg::KEY_W-1];
    tm = {rem_m_r, in_bit};
    tq = {rem_q_r, in_bit};
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    key_nxt   = key_r;
    step_nxt  = step_r;
    rem_m_nxt = rem_m_r;
    rem_q_nxt = rem_q_r;
    case (state_r)
      H_IDLE: begin
        if (start) begin
          key_nxt   = key;
          rem_m_nxt = '0;
          rem_q_nxt = '0;
          cnt_nxt   = dht_pkg::BIT_CNT_W'(dht_pkg::KEY_W - 1);
          state_nxt = H_KEY;
        end
      end
      H_KEY: begin
        key_nxt = {key_r[dht_pkg::KEY_W-2:0], 1'b0};
        if (tm >= {1'b0, m}) begin
          rem_m_nxt = dht_pkg::SIZE_W'(tm - {1'b0, m});
        end else begin
          rem_m_nxt = tm[dht_pkg::SIZE_W-1:0];
        end
        if (tq >= {1'b0, q}) begin
          rem_q_nxt = dht_pkg::Q_W'(tq - {1'b0, q});
        end else begin
          rem_q_nxt = tq[dht_pkg::Q_W-1:0];
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          // rem_m now holds the base slot, keep it in step_r's partner below
          step_nxt  = q - rem_q_nxt;
          rem_q_nxt = rem_m_nxt[dht_pkg::Q_W-1:0];
          rem_m_nxt = '0;
          cnt_nxt   = dht_pkg::BIT_CNT_W'(dht_pkg::Q_W - 1);
          state_nxt = H_STEP;
        end
      end
      H_STEP: begin
        step_nxt = {step_r[dht_pkg::Q_W-2:0], 1'b0};
        if (tm >= {1'b0, m}) begin
          rem_m_nxt = dht_pkg::SIZE_W'(tm - {1'b0, m});
        end else begin
          rem_m_nxt = tm[dht_pkg::SIZE_W-1:0];
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = H_DONE;
        end
      end
      H_DONE: begin
        state_nxt = H_IDLE;
      end
      default: begin
        state_nxt = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r   <= cnt_nxt;
    key_r   <= key_nxt;
    step_r  <= step_nxt;
    rem_m_r <= rem_m_nxt;
    rem_q_r <= rem_q_nxt;
  end

  // during the step phase rem_q_r carries the base slot
  assign done       = (state_r == H_DONE);
  assign hash.base  = rem_q_r;
  assign hash.stepm = rem_m_r[dht_pkg::SLOT_W-1:0];

  a_base_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> ({1'b0, hash.base} < m))
    else $error("base slot not below table size");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> ({1'b0, hash.stepm} < m))
    else $error("reduced step not below table size");

  a_done_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(state_r) == H_STEP)
    else $error("done without step phase");

endmodule

// ----- src/double_hash_table_unit.sv -----
// double hashing open-addressing table: slot memory, probe sequencer, output register
// depends on dht_pkg and dht_hash
//
//  port group  dir  handshake          beat
//  in_         in   in_valid/in_stall   dht_pkg::in_beat_t (command, key, slot_index)
//  out_        out  out_valid/out_stall dht_pkg::out_beat_t (status, slot, stored_key, collisions)
//  cfg_        in   cfg_valid/cfg_ready cfg_index, cfg_data (table_size, step_modulus)
//
// insert/search: accept, then bit-serial hashing (start, 31 key bits, 6 step bits, done),
// then per probe a memory read and a compare, then the beat goes to the output register;
// read slot: accept, slot read, response; zero key: accept, response;
// one item in flight at a time
// reset clears the valid bits of all 64 slots at once; no clearing pass
// the next input beat is taken while the last result still sits in the output register

module double_hash_table_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dht_pkg::in_beat_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dht_pkg::out_beat_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dht_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_HASH = 6'b000010,
    S_RD   = 6'b000100,
    S_CK   = 6'b001000,
    S_SLOT = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [dht_pkg::SIZE_W-1:0]      table_size_r;
  logic [dht_pkg::Q_W-1:0]         step_modulus_r;
  logic [dht_pkg::SIZE_W-1:0]      m_eff;
  logic [dht_pkg::Q_W-1:0]         q_eff;

  logic [dht_pkg::CMD_W-1:0]       cmd_r, cmd_nxt;
  logic [dht_pkg::KEY_W-1:0]       key_r, key_nxt;
  logic [dht_pkg::SLOT_W-1:0]      idx_r, idx_nxt;
  logic [dht_pkg::SLOT_W-1:0]      slot_r, slot_nxt;
  logic [dht_pkg::SLOT_W-1:0]      stepm_r, stepm_nxt;
  logic [dht_pkg::CNT_W-1:0]       probe_r, probe_nxt;
  dht_pkg::out_beat_t              res_r, res_nxt;
  logic                            out_valid_r, out_valid_nxt;
  dht_pkg::out_beat_t              out_data_r, out_data_nxt;

  logic [dht_pkg::KEY_W-1:0]       mem [dht_pkg::TABLE_SIZE];
  logic [dht_pkg::TABLE_SIZE-1:0]  vld_r;
  logic [dht_pkg::KEY_W-1:0]       rd_q;
  logic                            rd_vld_q;
  logic [dht_pkg::KEY_W-1:0]       word;
  logic [dht_pkg::SLOT_W-1:0]      rd_addr;
  logic                            wr_en;

  logic                            in_acc;
  logic                            hash_start;
  logic                            hash_done;
  dht_pkg::hash_t                  hash;
  logic [dht_pkg::SLOT_W:0]        slot_sum;
  logic [dht_pkg::SLOT_W-1:0]      slot_adv;
  logic [dht_pkg::CNT_W-1:0]       probe_inc;
  logic                            resp_go;

  dht_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (key_r),
    .m     (m_eff),
    .q     (q_eff),
    .done  (hash_done),
    .hash  (hash)
  );

  always_comb begin
    if (table_size_r < dht_pkg::SIZE_MIN) begin
      m_eff = dht_pkg::SIZE_MIN;
    end else if (table_size_r > dht_pkg::SIZE_MAX) begin
      m_eff = dht_pkg::SIZE_MAX;
    end else begin
      m_eff = table_size_r;
    end
    q_eff = (step_modulus_r == '0) ? dht_pkg::Q_W'(1) : step_modulus_r;
  end

  assign cfg_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r   <= dht_pkg::SIZE_RESET;
      step_modulus_r <= dht_pkg::Q_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dht_pkg::CFG_TABLE_SIZE: begin
          table_size_r <= cfg_data;
        end
        dht_pkg::CFG_STEP_MODULUS: begin
          step_modulus_r <= cfg_data[dht_pkg::Q_W-1:0];
        end
        default: begin
          table_size_r <= table_size_r;
        end
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // slot memory with valid bits; read data registered
  assign rd_addr = (state_r == S_IDLE) ? in_data.slot_index : slot_r;
  assign word    = rd_vld_q ? rd_q : '0;

  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    if (wr_en) begin
      mem[slot_r] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_r[rd_addr];
      if (wr_en) begin
        vld_r[slot_r] <= 1'b1;
      end
    end
  end

  assign slot_sum  = {1'b0, slot_r} + {1'b0, stepm_r};
  assign slot_adv  = (slot_sum >= m_eff) ? dht_pkg::SLOT_W'(slot_sum - m_eff)
                                         : slot_sum[dht_pkg::SLOT_W-1:0];
  assign probe_inc = probe_r + 1'b1;
  assign resp_go   = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    stepm_nxt     = stepm_r;
    probe_nxt     = probe_r;
    res_nxt       = res_r;
    hash_start    = 1'b0;
    wr_en         = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt = in_data.command;
          key_nxt = in_data.key;
          idx_nxt = in_data.slot_index;
          if (in_data.command[1]) begin
            state_nxt = S_SLOT;
          end else if (in_data.key == '0) begin
            res_nxt   = '{status: dht_pkg::ST_ZERO_KEY, slot: '0, stored_key: '0,
                          collisions: '0};
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        hash_start = !hash_done;
        if (hash_done) begin
          slot_nxt  = hash.base;
          stepm_nxt = hash.stepm;
          probe_nxt = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CK;
      end
      S_CK: begin
        state_nxt = S_RESP;
        if (cmd_r == dht_pkg::CMD_INSERT) begin
          if (word == '0) begin
            wr_en   = 1'b1;
            res_nxt = '{status: dht_pkg::ST_INSERTED, slot: slot_r, stored_key: key_r,
                        collisions: probe_r};
          end else if (probe_inc == m_eff) begin
            res_nxt = '{status: dht_pkg::ST_FULL, slot: '0, stored_key: '0,
                        collisions: m_eff};
          end else begin
            probe_nxt = probe_inc;
            slot_nxt  = slot_adv;
            state_nxt = S_RD;
          end
        end else begin
          if (word == '0) begin
            res_nxt = '{status: dht_pkg::ST_NOT_FOUND, slot: '0, stored_key: '0,
                        collisions: '0};
          end else if (word == key_r) begin
            res_nxt = '{status: dht_pkg::ST_FOUND, slot: slot_r, stored_key: key_r,
                        collisions: '0};
          end else if (probe_inc == m_eff) begin
            res_nxt = '{status: dht_pkg::ST_NOT_FOUND, slot: '0, stored_key: '0,
                        collisions: '0};
          end else begin
            probe_nxt = probe_inc;
            slot_nxt  = slot_adv;
            state_nxt = S_RD;
          end
        end
      end
      S_SLOT: begin
        res_nxt   = '{status: dht_pkg::ST_READ, slot: idx_r, stored_key: word,
                      collisions: '0};
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (resp_go) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    slot_r     <= slot_nxt;
    stepm_r    <= stepm_nxt;
    probe_r    <= probe_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted beat did not start work");

  a_write_only_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_CK) && (cmd_r == dht_pkg::CMD_INSERT) && (key_r != '0))
    else $error("slot write outside insert check");

  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> vld_r[$past(slot_r)])
    else $error("written slot not marked valid");

  a_probe_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CK) |-> (probe_r < m_eff) && ({1'b0, slot_r} < m_eff))
    else $error("probe past table size");

  a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) && out_valid_r && out_stall |=> state_r == S_RESP)
    else $error("result dropped while output register full");

endmodule

// ----- test/double_hash_table_unit_tb.sv -----
`timescale 1ns / 1ps
// testbench for double_hash_table_unit: directed table, then random phases under several
// table settings, each result checked against a listed answer or the in-bench slot model
// depends on dht_pkg and the double_hash_table_unit rtl

module double_hash_table_unit_tb;

  localparam logic [dht_pkg::CMD_W-1:0] CMD_SPARE = dht_pkg::CMD_W'(3);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 120;
  localparam int PHASE_ITEMS = 115;

  typedef struct {
    bit                             is_cfg;
    logic [dht_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [dht_pkg::CFG_DATA_W-1:0] reg_val;
    dht_pkg::in_beat_t              beat;
    bit                             typed;
    dht_pkg::out_beat_t             want;
  } plan_row_t;

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  dht_pkg::in_beat_t              in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  dht_pkg::out_beat_t             out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [dht_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dht_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic [dht_pkg::KEY_W-1:0]  slot_shadow [dht_pkg::TABLE_SIZE];
  logic [dht_pkg::SIZE_W-1:0] cur_table_size = dht_pkg::SIZE_RESET;
  logic [dht_pkg::Q_W-1:0]    cur_step_mod = dht_pkg::Q_RESET;
  dht_pkg::out_beat_t         pending_results [$];
  logic [dht_pkg::KEY_W-1:0]  known_keys [$];
  plan_row_t                  plan [$];

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_on = 1'b0;
  int  cycle_count = 0;
  int  n_mismatch = 0;
  int  n_items = 0;
  int  n_settings = 0;
  int  status_seen [8];
  event hold_off;

  double_hash_table_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // expected answer of the table for one command, updating the shadow store
  function automatic dht_pkg::out_beat_t table_response(dht_pkg::in_beat_t b);
    dht_pkg::out_beat_t r;
    int unsigned        m, q, k, s, i;
    r = '0;
    m = cur_table_size;
    if (m < 2) m = 2;
    if (m > dht_pkg::TABLE_SIZE) m = dht_pkg::TABLE_SIZE;
    q = (cur_step_mod == 0) ? 1 : cur_step_mod;
    k = b.key;
    if (b.command != dht_pkg::CMD_INSERT && b.command != dht_pkg::CMD_SEARCH) begin
      r.status = dht_pkg::ST_READ;
      r.slot = b.slot_index;
      r.stored_key = slot_shadow[b.slot_index];
      return r;
    end
    if (k == 0) begin
      r.status = dht_pkg::ST_ZERO_KEY;
      return r;
    end
    for (i = 0; i < m; i++) begin
      s = (k % m + i * (q - k % q)) % m;
      if (b.command == dht_pkg::CMD_INSERT) begin
        if (slot_shadow[s] == 0) begin
          slot_shadow[s] = b.key;
          r.status = dht_pkg::ST_INSERTED;
          r.slot = dht_pkg::SLOT_W'(s);
          r.stored_key = b.key;
          r.collisions = dht_pkg::CNT_W'(i);
          return r;
        end
      end else begin
        if (slot_shadow[s] == 0) break;
        if (slot_shadow[s] == b.key) begin
          r.status = dht_pkg::ST_FOUND;
          r.slot = dht_pkg::SLOT_W'(s);
          r.stored_key = b.key;
          return r;
        end
      end
    end
    if (b.command == dht_pkg::CMD_INSERT) begin
      r.status = dht_pkg::ST_FULL;
      r.collisions = dht_pkg::CNT_W'(m);
    end else begin
      r.status = dht_pkg::ST_NOT_FOUND;
    end
    return r;
  endfunction

  function automatic plan_row_t op(logic [dht_pkg::CMD_W-1:0] c,
                                   logic [dht_pkg::KEY_W-1:0] k,
                                   logic [dht_pkg::SLOT_W-1:0] ix);
    plan_row_t r;
    r = '{default: '0};
    r.beat.command = c;
    r.beat.key = k;
    r.beat.slot_index = ix;
    return r;
  endfunction

  function automatic plan_row_t op_known(logic [dht_pkg::CMD_W-1:0] c,
                                         logic [dht_pkg::KEY_W-1:0] k,
                                         logic [dht_pkg::SLOT_W-1:0] ix,
                                         logic [dht_pkg::STATUS_W-1:0] st,
                                         logic [dht_pkg::SLOT_W-1:0] sl,
                                         logic [dht_pkg::KEY_W-1:0] sk);
    plan_row_t r;
    r = op(c, k, ix);
    r.typed = 1'b1;
    r.want.status = st;
    r.want.slot = sl;
    r.want.stored_key = sk;
    r.want.collisions = '0;
    return r;
  endfunction

  function automatic plan_row_t set_reg(logic [dht_pkg::CFG_IDX_W-1:0] idx,
                                        logic [dht_pkg::CFG_DATA_W-1:0] val);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic logic [dht_pkg::KEY_W-1:0] rand_key();
    logic [dht_pkg::KEY_W-1:0] k;
    if ($urandom_range(1) == 0) k = dht_pkg::KEY_W'($urandom_range(200, 1));
    else k = dht_pkg::KEY_W'($urandom);
    if (k == 0) k = 1;
    return k;
  endfunction

  // mostly inserts and searches (searches mostly of keys inserted earlier), plus reads and zero keys
  function automatic dht_pkg::in_beat_t rand_beat();
    dht_pkg::in_beat_t b;
    int                pick;
    b.command = dht_pkg::CMD_W'($urandom);
    b.key = dht_pkg::KEY_W'($urandom);
    b.slot_index = dht_pkg::SLOT_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) begin
      b.command = dht_pkg::CMD_INSERT;
      b.key = rand_key();
      known_keys.push_back(b.key);
      if (known_keys.size() > 96) void'(known_keys.pop_front());
    end else if (pick < 75) begin
      b.command = dht_pkg::CMD_SEARCH;
      if (known_keys.size() != 0 && $urandom_range(9) < 7)
        b.key = known_keys[$urandom_range(known_keys.size() - 1)];
      else
        b.key = rand_key();
    end else if (pick < 93) begin
      b.command = ($urandom_range(3) == 0) ? CMD_SPARE : dht_pkg::CMD_READ;
    end else begin
      b.command = ($urandom_range(1) == 0) ? dht_pkg::CMD_INSERT : dht_pkg::CMD_SEARCH;
      b.key = '0;
    end
    return b;
  endfunction

  task automatic push_item(dht_pkg::in_beat_t b, bit typed, dht_pkg::out_beat_t want);
    dht_pkg::out_beat_t predicted;
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    predicted = table_response(b);
    pending_results.push_back(typed ? want : predicted);
    n_items++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [dht_pkg::CFG_IDX_W-1:0] idx,
                           logic [dht_pkg::CFG_DATA_W-1:0] val);
    wait_drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == dht_pkg::CFG_TABLE_SIZE) cur_table_size = val;
    else cur_step_mod = val[dht_pkg::Q_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [dht_pkg::CFG_DATA_W-1:0] m,
                           logic [dht_pkg::CFG_DATA_W-1:0] q,
                           int sidle, int rstall, bit pressure);
    dht_pkg::out_beat_t none;
    none = '0;
    write_reg(dht_pkg::CFG_TABLE_SIZE, m);
    write_reg(dht_pkg::CFG_STEP_MODULUS, q);
    n_settings++;
    send_idle_pct = sidle;
    stall_pct = rstall;
    if (pressure) -> hold_off;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (pressure && i == PHASE_ITEMS / 2) wait_drain();
      push_item(rand_beat(), 1'b0, none);
    end
  endtask

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(hold_off);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_on = 1'b0;
    end
  end

  always @(negedge clk) begin
    out_stall <= hold_on || (stall_pct != 0 && $urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : check_results
    dht_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      status_seen[out_data.status]++;
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result: status %0d slot %0d key %h coll %0d",
                   out_data.status, out_data.slot, out_data.stored_key, out_data.collisions);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.slot !== want.slot ||
            out_data.stored_key !== want.stored_key ||
            out_data.collisions !== want.collisions) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display({"mismatch: want st %0d slot %0d key %h coll %0d, ",
                      "got st %0d slot %0d key %h coll %0d"},
                     want.status, want.slot, want.stored_key, want.collisions,
                     out_data.status, out_data.slot, out_data.stored_key, out_data.collisions);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < dht_pkg::TABLE_SIZE; i++) slot_shadow[i] = '0;
    for (int i = 0; i < 8; i++) status_seen[i] = 0;

    plan.push_back(op_known(dht_pkg::CMD_READ, 31'h0, 6'd0, dht_pkg::ST_READ, 6'd0, 31'h0));
    plan.push_back(op_known(dht_pkg::CMD_READ, 31'h7FFFFFFF, 6'd63, dht_pkg::ST_READ,
                            6'd63, 31'h0));
    plan.push_back(op_known(dht_pkg::CMD_INSERT, 31'h0, 6'd63, dht_pkg::ST_ZERO_KEY,
                            6'd0, 31'h0));
    plan.push_back(op_known(dht_pkg::CMD_SEARCH, 31'h0, 6'd0, dht_pkg::ST_ZERO_KEY,
                            6'd0, 31'h0));
    plan.push_back(op_known(dht_pkg::CMD_SEARCH, 31'd5, 6'd0, dht_pkg::ST_NOT_FOUND,
                            6'd0, 31'h0));
    plan.push_back(op_known(dht_pkg::CMD_INSERT, 31'd5, 6'd0, dht_pkg::ST_INSERTED,
                            6'd5, 31'd5));
    plan.push_back(op_known(dht_pkg::CMD_SEARCH, 31'd5, 6'd0, dht_pkg::ST_FOUND,
                            6'd5, 31'd5));
    plan.push_back(op(dht_pkg::CMD_INSERT, 31'd18, 6'd0));
    plan.push_back(op(dht_pkg::CMD_SEARCH, 31'd18, 6'd0));
    plan.push_back(op(dht_pkg::CMD_INSERT, 31'h7FFFFFFF, 6'd0));
    plan.push_back(op(dht_pkg::CMD_SEARCH, 31'h7FFFFFFF, 6'd0));
    plan.push_back(op_known(CMD_SPARE, 31'h0, 6'd5, dht_pkg::ST_READ, 6'd5, 31'd5));
    plan.push_back(op(dht_pkg::CMD_INSERT, 31'd5, 6'd0));
    plan.push_back(op(dht_pkg::CMD_SEARCH, 31'h2AAAAAAA, 6'h2A));
    plan.push_back(op(dht_pkg::CMD_INSERT, 31'h55555555, 6'h15));
    plan.push_back(op(dht_pkg::CMD_READ, 31'h2AAAAAAA, 6'h2A));
    plan.push_back(op(dht_pkg::CMD_READ, 31'h55555555, 6'h15));
    // two slots, unit step: the table fills after two inserts
    plan.push_back(set_reg(dht_pkg::CFG_TABLE_SIZE, 7'd2));
    plan.push_back(set_reg(dht_pkg::CFG_STEP_MODULUS, 7'd0));
    plan.push_back(op(dht_pkg::CMD_INSERT, 31'd3, 6'd0));
    plan.push_back(op(dht_pkg::CMD_INSERT, 31'd6, 6'd0));
    plan.push_back(op(dht_pkg::CMD_INSERT, 31'd9, 6'd0));
    plan.push_back(op(dht_pkg::CMD_INSERT, 31'd12, 6'd0));
    plan.push_back(op(dht_pkg::CMD_SEARCH, 31'd7, 6'd0));
    // step equal to the table size never leaves the home slot
    plan.push_back(set_reg(dht_pkg::CFG_TABLE_SIZE, 7'd4));
    plan.push_back(set_reg(dht_pkg::CFG_STEP_MODULUS, 7'd4));
    plan.push_back(op(dht_pkg::CMD_INSERT, 31'd4, 6'd0));
    plan.push_back(op(dht_pkg::CMD_INSERT, 31'd8, 6'd0));
    plan.push_back(set_reg(dht_pkg::CFG_TABLE_SIZE, 7'd127));
    plan.push_back(set_reg(dht_pkg::CFG_STEP_MODULUS, 7'd63));
    plan.push_back(op(dht_pkg::CMD_INSERT, 31'h40000000, 6'd0));
    plan.push_back(op(dht_pkg::CMD_SEARCH, 31'h40000000, 6'd0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    n_settings = 1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else push_item(plan[i].beat, plan[i].typed, plan[i].want);
    end

    run_phase(7'd5, 7'd3, 0, 0, 1'b0);
    run_phase(7'd0, 7'd1, 64, 0, 1'b0);
    run_phase(7'd17, 7'd63, 0, 64, 1'b0);
    run_phase(7'd31, 7'd2, 24, 24, 1'b1);
    run_phase(7'd64, 7'd7, 0, 0, 1'b0);
    run_phase(7'd127, 7'd62, 64, 0, 1'b0);
    run_phase(7'd7, 7'd5, 0, 64, 1'b0);
    run_phase(7'd1, 7'd63, 24, 24, 1'b0);

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d commands over %0d table settings in %0d cycles, %0d mismatches",
             n_items, n_settings, cycle_count, n_mismatch);
    $display("results: %0d inserted, %0d full, %0d found, %0d missed, %0d reads, %0d zero key",
             status_seen[dht_pkg::ST_INSERTED], status_seen[dht_pkg::ST_FULL],
             status_seen[dht_pkg::ST_FOUND], status_seen[dht_pkg::ST_NOT_FOUND],
             status_seen[dht_pkg::ST_READ], status_seen[dht_pkg::ST_ZERO_KEY]);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/dht_pkg.sv
src/dht_hash.sv
src/double_hash_table_unit.sv
test/double_hash_table_unit_tb.sv
